// ----- hw/rtl/assert_macros.svh -----
// Concurrent assertion helpers; clk and rst_n must be visible at the use site.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Invariant checked at every rising clock edge outside reset.
`define CCS_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Same-cycle implication checked outside reset.
`define CCS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ----- hw/rtl/ccs_pkg.sv -----
package ccs_pkg;

  localparam int MAX_RES     = 4;
  localparam int CNT_W       = $clog2(MAX_RES + 1);
  localparam int SUB_W       = $clog2(MAX_RES);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_NL    = 8'h0A;

  typedef enum logic [5:0] {
    M_NORMAL = 6'b000001,
    M_SLASH  = 6'b000010,
    M_SLASH2 = 6'b000100,
    M_LINE   = 6'b001000,
    M_BLOCK  = 6'b010000,
    M_BSTAR  = 6'b100000
  } mode_t;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       last;
    logic       error;
  } res_t;

  // All results caused by one input beat.
  typedef struct packed {
    res_t [MAX_RES-1:0] res;
    logic [CNT_W-1:0]   cnt;
  } entry_t;

endpackage

// ----- hw/rtl/ccs_in_if.sv -----
interface ccs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

// ----- hw/rtl/ccs_out_if.sv -----
interface ccs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_has_byte;
  logic       out_last;
  logic       out_error;

  modport source (output valid, output out_byte, output out_has_byte, output out_last,
                  output out_error, input ready);
  modport sink (input valid, input out_byte, input out_has_byte, input out_last,
                input out_error, output ready);
endinterface

// ----- hw/rtl/c_comment_stripper.sv -----
// An input beat's results are held in a queue entry, then in the output register.
// Throughput: one input beat per cycle while each byte yields at most one result and
// the output is not stalled; a byte yielding k results (k up to 4) holds the single
// output register for each result in turn, absorbed by a 2-entry queue before the
// input stalls. Comment bytes yield nothing. Reset: synchronous, active-low rst_n
// clears scan mode, held newline, queue and output valid.
module c_comment_stripper
  import ccs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  ccs_in_if.sink     in_ch,
  ccs_out_if.source  out_ch
);

  logic   push_valid, push_ready;
  entry_t push_entry;
  logic   head_valid, pop;
  entry_t head_entry;

  ccs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready)
  );

  ccs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop)
  );

  ccs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

// ----- hw/rtl/ccs_front.sv -----
module ccs_front
  import ccs_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  ccs_in_if.sink in_ch,
  output logic   push_valid,
  output entry_t push_entry,
  input  logic   push_ready
);

  typedef struct packed {
    res_t [MAX_RES-1:0] res;
    logic [CNT_W-1:0]   cnt;
    logic               held;
    mode_t              mode;
  } acc_t;

  function automatic res_t mk_byte(logic [7:0] b);
    res_t r;
    r.data     = b;
    r.has_byte = 1'b1;
    r.last     = 1'b0;
    r.error    = 1'b0;
    return r;
  endfunction

  function automatic acc_t acc_put(acc_t a, res_t r);
    acc_t o;
    o = a;
    if (a.cnt < CNT_W'(MAX_RES)) begin
      o.res[a.cnt[SUB_W-1:0]] = r;
      o.cnt = a.cnt + CNT_W'(1);
    end
    return o;
  endfunction

  // Newlines are held back since the stream's final one is dropped.
  function automatic acc_t acc_emit(acc_t a, logic [7:0] b);
    acc_t o;
    o = a;
    if (b == CH_NL) begin
      if (a.held) o = acc_put(o, mk_byte(CH_NL));
      o.held = 1'b1;
    end else begin
      if (a.held) begin
        o = acc_put(o, mk_byte(CH_NL));
        o.held = 1'b0;
      end
      o = acc_put(o, mk_byte(b));
    end
    return o;
  endfunction

  function automatic acc_t acc_scan(acc_t a, logic [7:0] c);
    acc_t o;
    o = a;
    case (a.mode)
      M_SLASH: begin
        if (c == CH_SLASH) begin
          o.mode = M_SLASH2;
        end else if (c == CH_STAR) begin
          o.mode = M_BLOCK;
        end else begin
          o = acc_emit(acc_emit(o, CH_SLASH), c);
          o.mode = M_NORMAL;
        end
      end
      M_SLASH2: begin
        if (c == CH_BANG) begin
          o = acc_emit(acc_emit(acc_emit(o, CH_SLASH), CH_SLASH), CH_BANG);
          o.mode = M_NORMAL;
        end else if (c == CH_NL) begin
          o = acc_emit(o, CH_NL);
          o.mode = M_NORMAL;
        end else begin
          o.mode = M_LINE;
        end
      end
      M_LINE: begin
        if (c == CH_NL) begin
          o = acc_emit(o, CH_NL);
          o.mode = M_NORMAL;
        end
      end
      M_BLOCK: begin
        if (c == CH_STAR) o.mode = M_BSTAR;
      end
      M_BSTAR: begin
        if (c == CH_SLASH) begin
          o.mode = M_NORMAL;
        end else if (c != CH_STAR) begin
          o.mode = M_BLOCK;
        end
      end
      default: begin
        if (c == CH_SLASH) begin
          o.mode = M_SLASH;
        end else begin
          o = acc_emit(o, c);
          o.mode = M_NORMAL;
        end
      end
    endcase
    return o;
  endfunction

  mode_t            mode_r, mode_nxt;
  logic             held_r, held_nxt;
  acc_t             acc0, acc1, acc2, acc3;
  res_t             marker;
  logic [SUB_W-1:0] tail_idx;
  logic             accept;

  always_comb begin
    acc0.res  = '0;
    acc0.cnt  = '0;
    acc0.held = held_r;
    acc0.mode = mode_r;
    acc1 = acc_scan(acc0, in_ch.in_byte);
    acc2 = (in_ch.in_last && (in_ch.in_byte != CH_NL)) ? acc_scan(acc1, CH_NL) : acc1;
    tail_idx = SUB_W'(acc2.cnt - CNT_W'(1));
    marker.data     = '0;
    marker.has_byte = 1'b0;
    marker.last     = 1'b1;
    marker.error    = 1'b0;
    acc3 = acc2;
    if (in_ch.in_last) begin
      if ((acc2.mode == M_BLOCK) || (acc2.mode == M_BSTAR)) begin
        marker.error = 1'b1;
        acc3 = acc_put(acc2, marker);
      end else if (acc2.cnt != '0) begin
        acc3.res[tail_idx].last = 1'b1;
      end else begin
        acc3 = acc_put(acc2, marker);
      end
    end
  end

  assign accept         = in_ch.valid && in_ch.ready;
  assign in_ch.ready    = push_ready;
  assign push_valid     = in_ch.valid && (acc3.cnt != '0);
  assign push_entry.res = acc3.res;
  assign push_entry.cnt = acc3.cnt;

  always_comb begin
    mode_nxt = mode_r;
    held_nxt = held_r;
    if (accept) begin
      if (in_ch.in_last) begin
        mode_nxt = M_NORMAL;
        held_nxt = 1'b0;
      end else begin
        mode_nxt = acc2.mode;
        held_nxt = acc2.held;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_NORMAL;
      held_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      held_r <= held_nxt;
    end
  end

endmodule

// ----- hw/rtl/ccs_queue.sv -----
`include "assert_macros.svh"

module ccs_queue
  import ccs_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push_valid,
  input  entry_t push_entry,
  output logic   push_ready,
  output logic   head_valid,
  output entry_t head_entry,
  input  logic   pop
);

  entry_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]   count_r, count_nxt;
  logic                push;

  assign push_ready = (count_r < QCNT_W'(QUEUE_DEPTH));
  assign push       = push_valid && push_ready;
  assign head_valid = (count_r != '0);
  assign head_entry = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + QCNT_W'(1);
    if (!push && pop) count_nxt = count_r - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop) rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      count_r <= count_nxt;
    end
  end

  `CCS_ASSERT(a_cnt_bound, count_r <= QCNT_W'(QUEUE_DEPTH), "queue count above depth")
  `CCS_ASSERT_IMP(a_empty_ptrs, count_r == '0, wr_ptr_r == rd_ptr_r, "empty queue, pointers differ")

endmodule

// ----- hw/rtl/ccs_back.sv -----
`include "assert_macros.svh"

module ccs_back
  import ccs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_valid,
  input  entry_t     head_entry,
  output logic       pop,
  ccs_out_if.source  out_ch
);

  logic [SUB_W-1:0] sub_r, sub_nxt;
  res_t             out_res_r;
  logic             out_valid_r, out_valid_nxt;
  logic             load;
  logic             final_res;

  assign load      = head_valid && (!out_valid_r || out_ch.ready);
  assign final_res = ((CNT_W'(sub_r) + CNT_W'(1)) == head_entry.cnt);
  assign pop       = load && final_res;

  always_comb begin
    sub_nxt       = sub_r;
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) out_valid_nxt = 1'b0;
    if (load) begin
      out_valid_nxt = 1'b1;
      sub_nxt       = final_res ? '0 : sub_r + SUB_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_res_r <= head_entry.res[sub_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sub_r       <= sub_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.out_byte     = out_res_r.data;
  assign out_ch.out_has_byte = out_res_r.has_byte;
  assign out_ch.out_last     = out_res_r.last;
  assign out_ch.out_error    = out_res_r.error;

  `CCS_ASSERT_IMP(a_head_cnt, head_valid, (head_entry.cnt != '0) && (head_entry.cnt <= CNT_W'(MAX_RES)), "bad entry count")
  `CCS_ASSERT_IMP(a_sub_range, head_valid, CNT_W'(sub_r) < head_entry.cnt, "result index past entry")
  `CCS_ASSERT_IMP(a_err_marker, out_valid_r && out_res_r.error, out_res_r.last && !out_res_r.has_byte, "error beat malformed")

endmodule
